// ===== design/gwl_pkg.sv =====
// shared types, constants and window setup for the window/level grey lookup
package gwl_pkg;

  localparam int CodeW    = 8;
  localparam int HalfW    = 7;
  localparam int LevelW   = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;
  localparam int AccW     = 16;
  localparam int PosW     = 10;

  localparam logic [LevelW-1:0] RampTop  = 8'd255;
  localparam logic [HalfW-1:0]  WinMax   = 7'd127;
  localparam logic [CodeW-1:0]  OvlCode  = 8'd128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_LEVEL      = 3'd0,
    CFG_HIGH_LEVEL     = 3'd1,
    CFG_BLACK_TO_WHITE = 3'd2,
    CFG_OVERLAY_STYLE  = 3'd3,
    CFG_OVERLAY_VALUE  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0] lo_eff;
    logic                   inv;
    logic [LevelW-1:0]      den;
    logic [LevelW-1:0]      win_lo;
    logic [HalfW-1:0]       win_hi;
  } win_t;

  typedef struct packed {
    logic              en;
    logic [HalfW-1:0]  addr;
    logic [LevelW-1:0] data;
  } lut_wr_t;

  function automatic win_t calc_window(logic [LevelW-1:0] lo, logic [LevelW-1:0] hi);
    win_t                   w;
    logic signed [PosW-1:0] lo_s;
    logic signed [PosW-1:0] hi_s;
    logic signed [PosW-1:0] mn;
    logic signed [PosW-1:0] mx;
    logic signed [PosW-1:0] diff;
    lo_s = signed'({2'b00, lo});
    hi_s = signed'({2'b00, hi});
    if (hi == lo) begin
      lo_s = hi_s - 10'sd1;
    end
    w.lo_eff = lo_s;
    w.inv    = hi_s < lo_s;
    mn       = w.inv ? hi_s : lo_s;
    mx       = w.inv ? lo_s : hi_s;
    w.win_lo = (mn < 10'sd1) ? 8'd1 : mn[LevelW-1:0];
    w.win_hi = (mx > 10'sd127) ? WinMax : mx[HalfW-1:0];
    diff     = w.inv ? (lo_s - hi_s) : (hi_s - lo_s);
    w.den    = diff[LevelW-1:0];
    return w;
  endfunction

endpackage

// ===== design/gwl_ramp_fill.sv =====
// ramp table fill engine: step divider then incremental sweep over the window
module gwl_ramp_fill
  import gwl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    restart_i,
  input  win_t    win_i,
  output logic    busy_o,
  output lut_wr_t wr_o
);

  typedef enum logic [1:0] {
    FILL_DIV,
    FILL_SWEEP,
    FILL_IDLE
  } fill_state_e;

  fill_state_e            state_q;
  logic [2:0]             div_cnt_q;
  logic [LevelW-1:0]      rem_q;
  logic [LevelW-1:0]      quo_q;
  logic [LevelW-1:0]      k_q;
  logic [LevelW-1:0]      frac_q;
  logic [AccW-1:0]        acc_q;

  logic [LevelW:0]        trial;
  logic                   trial_ge;
  logic [LevelW:0]        trial_sub;
  logic [LevelW-1:0]      rem_d;
  logic [LevelW:0]        sum;
  logic                   wrap;
  logic [LevelW:0]        sum_sub;
  logic [LevelW-1:0]      frac_d;
  logic [AccW-1:0]        acc_d;
  logic signed [PosW-1:0] pos;
  logic                   in_win;

  always_comb begin
    trial     = {rem_q, 1'b1};
    trial_ge  = trial >= {1'b0, win_i.den};
    trial_sub = trial - {1'b0, win_i.den};
    rem_d     = trial_ge ? trial_sub[LevelW-1:0] : trial[LevelW-1:0];

    sum     = {1'b0, frac_q} + {1'b0, rem_q};
    wrap    = sum >= {1'b0, win_i.den};
    sum_sub = sum - {1'b0, win_i.den};
    frac_d  = wrap ? sum_sub[LevelW-1:0] : sum[LevelW-1:0];
    acc_d   = acc_q + {{(AccW-LevelW){1'b0}}, quo_q} + {{(AccW-1){1'b0}}, wrap};

    pos    = win_i.inv ? (win_i.lo_eff - signed'({2'b00, k_q}))
                       : (win_i.lo_eff + signed'({2'b00, k_q}));
    in_win = (pos >= signed'({2'b00, win_i.win_lo})) &&
             (pos <= signed'({3'b000, win_i.win_hi}));

    wr_o.en   = (state_q == FILL_SWEEP) && in_win;
    wr_o.addr = pos[HalfW-1:0];
    wr_o.data = acc_q[LevelW-1:0];
    busy_o    = state_q != FILL_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FILL_DIV;
      div_cnt_q <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      k_q       <= '0;
      frac_q    <= '0;
      acc_q     <= '0;
    end else if (restart_i) begin
      state_q   <= FILL_DIV;
      div_cnt_q <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
    end else begin
      case (state_q)
        FILL_DIV: begin
          rem_q     <= rem_d;
          quo_q     <= {quo_q[LevelW-2:0], trial_ge};
          div_cnt_q <= div_cnt_q + 3'd1;
          if (div_cnt_q == 3'd7) begin
            state_q <= FILL_SWEEP;
            k_q     <= '0;
            frac_q  <= '0;
            acc_q   <= '0;
          end
        end
        FILL_SWEEP: begin
          frac_q <= frac_d;
          acc_q  <= acc_d;
          k_q    <= k_q + 8'd1;
          if (k_q == RampTop) begin
            state_q <= FILL_IDLE;
          end
        end
        FILL_IDLE: begin
          state_q <= FILL_IDLE;
        end
        default: begin
          state_q <= FILL_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/grey_window_lut_with_overlay_core.sv =====
// window/level grey lookup with overlay plane: top level
//
// Input channel: in_valid_i, in_stall_o with pixel code and overlay flag. An
// item is taken at an edge with valid high and stall low. Output channel:
// out_valid_o, out_stall_i with the grey level, one result per item, in order.
// Configuration: cfg_valid_i / cfg_ready_o write register cfg_index_i
// (0 low_level, 1 high_level, 2 black_to_white, 3 overlay_style,
// 4 overlay_value); other indexes are ignored. cfg_ready_o is always high.
// Items pass the read stage, then the output register; one item per cycle is
// sustained while no ramp rebuild or receiver stall holds the flow, set by the
// single read port of the 128-entry ramp memory. The ramp memory is rebuilt
// after reset and after every write of low_level or high_level, by a step
// divider then a sweep with in_stall_o high. Other registers act at once.
// When the receiver stalls, the output register holds and one more item can
// sit in the read stage; beyond that in_stall_o follows out_stall_i.
module grey_window_lut_with_overlay_core
  import gwl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CodeW-1:0]    in_pixel_code_i,
  input  logic                in_overlay_shown_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LevelW-1:0]   out_grey_level_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [LevelW-1:0] low_level_q;
  logic [LevelW-1:0] high_level_q;
  logic [LevelW-1:0] black_to_white_q;
  logic              overlay_style_q;
  logic [LevelW-1:0] overlay_value_q;

  logic [LevelW-1:0] mem_q [2**HalfW];
  logic [LevelW-1:0] rdata_q;
  logic [HalfW-1:0]  raddr;

  logic              s1_valid_q;
  logic [CodeW-1:0]  s1_code_q;
  logic              s1_shown_q;
  logic              out_valid_q;
  logic [LevelW-1:0] out_level_q;
  logic [LevelW-1:0] level_d;

  win_t              win;
  lut_wr_t           lut_wr;
  logic              fill_busy;
  logic              cfg_we;
  logic              restart;
  logic              out_free;
  logic              in_take;
  logic [HalfW-1:0]  half;
  logic [LevelW-1:0] half_level;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && ((cfg_index_i == CFG_LOW_LEVEL) ||
                                  (cfg_index_i == CFG_HIGH_LEVEL));
  assign win         = calc_window(low_level_q, high_level_q);

  gwl_ramp_fill u_fill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .win_i     (win),
    .busy_o    (fill_busy),
    .wr_o      (lut_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_level_q      <= '0;
      high_level_q     <= 8'd127;
      black_to_white_q <= 8'd128;
      overlay_style_q  <= 1'b0;
      overlay_value_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_LOW_LEVEL:      low_level_q      <= cfg_data_i;
        CFG_HIGH_LEVEL:     high_level_q     <= cfg_data_i;
        CFG_BLACK_TO_WHITE: black_to_white_q <= cfg_data_i;
        CFG_OVERLAY_STYLE:  overlay_style_q  <= cfg_data_i[0];
        CFG_OVERLAY_VALUE:  overlay_value_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = fill_busy || (s1_valid_q && !out_free);
  assign in_take    = in_valid_i && !in_stall_o;
  assign raddr      = in_take ? in_pixel_code_i[HalfW-1:0] : s1_code_q[HalfW-1:0];

  always_ff @(posedge clk_i) begin
    if (lut_wr.en) begin
      mem_q[lut_wr.addr] <= lut_wr.data;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    half = s1_code_q[HalfW-1:0];
    if (half == '0) begin
      half_level = '0;
    end else if (half > win.win_hi) begin
      half_level = win.inv ? '0 : RampTop;
    end else if ({1'b0, half} < win.win_lo) begin
      half_level = win.inv ? RampTop : '0;
    end else begin
      half_level = rdata_q;
    end

    if (!s1_code_q[CodeW-1]) begin
      level_d = half_level;
    end else if (s1_code_q == OvlCode) begin
      level_d = overlay_style_q ? overlay_value_q : RampTop;
    end else if (!s1_shown_q) begin
      level_d = half_level;
    end else if (overlay_style_q) begin
      level_d = overlay_value_q;
    end else begin
      level_d = (half_level < black_to_white_q) ? RampTop : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_code_q  <= in_pixel_code_i;
      s1_shown_q <= in_overlay_shown_i;
    end
    if (out_free && s1_valid_q) begin
      out_level_q <= level_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_grey_level_o = out_level_q;

endmodule

// ===== design/gwl_checker.sv =====
// port-level checker for the window/level grey lookup, bound to the top level
module gwl_checker
  import gwl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [LevelW-1:0]   out_grey_level_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_grey_level_o))
    else $error("stalled result changed");

  a_refill_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o &&
    ((cfg_index_i == CFG_LOW_LEVEL) || (cfg_index_i == CFG_HIGH_LEVEL))
    |=> in_stall_o)
    else $error("input not stalled during ramp rebuild");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(in_acc) |=> !out_valid_o)
    else $error("result without a pending item");

endmodule

bind grey_window_lut_with_overlay_core gwl_checker u_gwl_checker (.*);
